/* rtl/pol_pkg.sv */
// Shared types and constants for the priority ordered lock.
`timescale 1ns / 1ps

package pol_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int ID_BITS     = 16;
   localparam int ADDR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ID_BITS-1:0]   id_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef enum logic [0:0] {
      CMD_ACQUIRE = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_QUEUED   = 3'd1,
      ST_RELEASED = 3'd2,
      ST_REFUSED  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] requester_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        handover_valid;
      logic [15:0] new_owner_id;
      logic [6:0]  waiting_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_INS_WALK,
      S_POP_HEAD,
      S_POP_SHIFT,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_GRANT,
      OP_FREE,
      OP_INS_START,
      OP_INS_STEP,
      OP_INS_PLACE,
      OP_POP_START,
      OP_POP_HEAD,
      OP_POP_STEP,
      OP_POP_DONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       set_result;
      status_type result_code;
      logic       handover;
      logic       rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic acquire;
      logic held;
      logic is_owner;
      logic full;
      logic empty;
      logic walk_more;
      logic shift_more;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/pol_ctrl.sv */
// Controller state machine for the priority ordered lock.
`timescale 1ns / 1ps

module pol_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pol_pkg::dp_status_type dp_status,
   output pol_pkg::ctrl_cmd_type  dp_cmd
);

   pol_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pol_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pol_pkg::S_IDLE: begin
            if (req_valid) state_in = pol_pkg::S_DECIDE;
         end
         pol_pkg::S_DECIDE: begin
            if (dp_status.acquire) begin
               if (dp_status.held && !dp_status.full) state_in = pol_pkg::S_INS_WALK;
               else state_in = pol_pkg::S_FINISH;
            end else begin
               if (dp_status.held && dp_status.is_owner && !dp_status.empty)
                  state_in = pol_pkg::S_POP_HEAD;
               else
                  state_in = pol_pkg::S_FINISH;
            end
         end
         pol_pkg::S_INS_WALK: begin
            if (!dp_status.walk_more) state_in = pol_pkg::S_FINISH;
         end
         pol_pkg::S_POP_HEAD: begin
            state_in = pol_pkg::S_POP_SHIFT;
         end
         pol_pkg::S_POP_SHIFT: begin
            if (!dp_status.shift_more) state_in = pol_pkg::S_FINISH;
         end
         pol_pkg::S_FINISH: begin
            if (dp_status.out_free) state_in = pol_pkg::S_IDLE;
         end
         default: begin
            state_in = pol_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready          = 1'b0;
      dp_cmd.op          = pol_pkg::OP_NONE;
      dp_cmd.set_result  = 1'b0;
      dp_cmd.result_code = pol_pkg::ST_GRANTED;
      dp_cmd.handover    = 1'b0;
      dp_cmd.rsp_load    = 1'b0;
      case (state_ff)
         pol_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) dp_cmd.op = pol_pkg::OP_LOAD;
         end
         pol_pkg::S_DECIDE: begin
            if (dp_status.acquire) begin
               if (!dp_status.held) begin
                  dp_cmd.op          = pol_pkg::OP_GRANT;
                  dp_cmd.set_result  = 1'b1;
                  dp_cmd.result_code = pol_pkg::ST_GRANTED;
               end else if (dp_status.full) begin
                  dp_cmd.set_result  = 1'b1;
                  dp_cmd.result_code = pol_pkg::ST_FULL;
               end else begin
                  dp_cmd.op = pol_pkg::OP_INS_START;
               end
            end else begin
               if (!dp_status.held || !dp_status.is_owner) begin
                  dp_cmd.set_result  = 1'b1;
                  dp_cmd.result_code = pol_pkg::ST_REFUSED;
               end else if (dp_status.empty) begin
                  dp_cmd.op          = pol_pkg::OP_FREE;
                  dp_cmd.set_result  = 1'b1;
                  dp_cmd.result_code = pol_pkg::ST_RELEASED;
               end else begin
                  dp_cmd.op = pol_pkg::OP_POP_START;
               end
            end
         end
         pol_pkg::S_INS_WALK: begin
            if (dp_status.walk_more) begin
               dp_cmd.op = pol_pkg::OP_INS_STEP;
            end else begin
               dp_cmd.op          = pol_pkg::OP_INS_PLACE;
               dp_cmd.set_result  = 1'b1;
               dp_cmd.result_code = pol_pkg::ST_QUEUED;
            end
         end
         pol_pkg::S_POP_HEAD: begin
            dp_cmd.op = pol_pkg::OP_POP_HEAD;
         end
         pol_pkg::S_POP_SHIFT: begin
            if (dp_status.shift_more) begin
               dp_cmd.op = pol_pkg::OP_POP_STEP;
            end else begin
               dp_cmd.op          = pol_pkg::OP_POP_DONE;
               dp_cmd.set_result  = 1'b1;
               dp_cmd.result_code = pol_pkg::ST_RELEASED;
               dp_cmd.handover    = 1'b1;
            end
         end
         pol_pkg::S_FINISH: begin
            dp_cmd.rsp_load = dp_status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/pol_dpath.sv */
// Datapath of the priority ordered lock: lock state, sorted wait queue, result register.
`timescale 1ns / 1ps

module pol_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  pol_pkg::req_type       req_data,
   input  pol_pkg::ctrl_cmd_type  dp_cmd,
   output pol_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pol_pkg::rsp_type       rsp_data
);

   // wait queue, sorted ascending; only the first len_ff entries are live
   pol_pkg::id_type     wait_ids_ff [pol_pkg::QUEUE_DEPTH];

   logic                held_ff, held_in;
   pol_pkg::id_type     owner_ff, owner_in;
   pol_pkg::cnt_type    len_ff, len_in;
   pol_pkg::cnt_type    ptr_ff, ptr_in;
   pol_pkg::id_type     id_ff;
   pol_pkg::cmd_type    cmd_ff;
   pol_pkg::id_type     rdata_ff;
   pol_pkg::status_type result_ff;
   logic                handover_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   pol_pkg::rsp_type    rsp_data_ff;

   pol_pkg::cnt_type    raddr_wide;
   pol_pkg::cnt_type    waddr_wide;
   pol_pkg::id_type     wdata;
   logic                wen;

   always_comb begin
      held_in    = held_ff;
      owner_in   = owner_ff;
      len_in     = len_ff;
      ptr_in     = ptr_ff;
      raddr_wide = ptr_ff;
      waddr_wide = ptr_ff;
      wdata      = rdata_ff;
      wen        = 1'b0;
      case (dp_cmd.op)
         pol_pkg::OP_GRANT: begin
            held_in  = 1'b1;
            owner_in = id_ff;
         end
         pol_pkg::OP_FREE: begin
            held_in  = 1'b0;
            owner_in = '0;
         end
         pol_pkg::OP_INS_START: begin
            ptr_in     = len_ff;
            raddr_wide = len_ff - pol_pkg::cnt_type'(1);
         end
         pol_pkg::OP_INS_STEP: begin
            wen        = 1'b1;
            ptr_in     = ptr_ff - pol_pkg::cnt_type'(1);
            raddr_wide = ptr_ff - pol_pkg::cnt_type'(2);
         end
         pol_pkg::OP_INS_PLACE: begin
            wen    = 1'b1;
            wdata  = id_ff;
            len_in = len_ff + pol_pkg::cnt_type'(1);
         end
         pol_pkg::OP_POP_START: begin
            ptr_in     = pol_pkg::cnt_type'(1);
            raddr_wide = '0;
         end
         pol_pkg::OP_POP_HEAD: begin
            owner_in = rdata_ff;
         end
         pol_pkg::OP_POP_STEP: begin
            wen        = 1'b1;
            waddr_wide = ptr_ff - pol_pkg::cnt_type'(1);
            ptr_in     = ptr_ff + pol_pkg::cnt_type'(1);
            raddr_wide = ptr_ff + pol_pkg::cnt_type'(1);
         end
         pol_pkg::OP_POP_DONE: begin
            len_in = len_ff - pol_pkg::cnt_type'(1);
         end
         default: begin
            wen = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) wait_ids_ff[waddr_wide[pol_pkg::ADDR_BITS-1:0]] <= wdata;
      rdata_ff <= wait_ids_ff[raddr_wide[pol_pkg::ADDR_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         owner_ff <= '0;
         len_ff   <= '0;
      end else begin
         held_ff  <= held_in;
         owner_ff <= owner_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (dp_cmd.op == pol_pkg::OP_LOAD) begin
         cmd_ff <= req_data.cmd;
         id_ff  <= pol_pkg::id_type'(32'(req_data.requester_id));
      end
      if (dp_cmd.set_result) begin
         result_ff   <= dp_cmd.result_code;
         handover_ff <= dp_cmd.handover;
      end
      if (dp_cmd.rsp_load) begin
         rsp_data_ff.status         <= result_ff;
         rsp_data_ff.handover_valid <= handover_ff;
         rsp_data_ff.new_owner_id   <= held_ff ? 16'(owner_ff) : 16'd0;
         rsp_data_ff.waiting_count  <= 7'(len_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (dp_cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign dp_status.acquire    = (cmd_ff == pol_pkg::CMD_ACQUIRE);
   assign dp_status.held       = held_ff;
   assign dp_status.is_owner   = (owner_ff == id_ff);
   assign dp_status.full       = (len_ff == pol_pkg::cnt_type'(pol_pkg::QUEUE_DEPTH));
   assign dp_status.empty      = (len_ff == '0);
   assign dp_status.walk_more  = (ptr_ff != '0) && (rdata_ff > id_ff);
   assign dp_status.shift_more = (ptr_ff < len_ff);
   assign dp_status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/priority_ordered_lock.sv */
// Top level of the priority ordered lock with an id-sorted wait queue.
//
//   channel | ports                         | direction | payload
//   --------+-------------------------------+-----------+------------------------------
//   request | req_valid req_ready req_data  | in        | cmd, requester_id
//   result  | rsp_valid rsp_ready rsp_data  | out       | status, handover, owner, count
//
// One transaction at a time. Grant, refuse and full go from accept through the decide
// state to the finish state. An insert walks the queue from the tail, one entry a cycle.
// A handover shifts the queue one entry a cycle.
// Synchronous reset frees the lock and empties the queue; no clearing pass.
// A stalled result holds in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps

module priority_ordered_lock (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pol_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pol_pkg::rsp_type rsp_data
);

   pol_pkg::ctrl_cmd_type  dp_cmd;
   pol_pkg::dp_status_type dp_status;

   pol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   pol_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/pol_checker.sv */
// Transaction checker for the priority ordered lock: predicts each response and compares it.
`timescale 1ns / 1ps

module pol_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pol_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pol_pkg::rsp_type rsp_data,
   output int               errors,
   output int               pending,
   output logic             lock_held,
   output pol_pkg::id_type  lock_owner,
   output int               queue_len
);

   logic             held;
   pol_pkg::id_type  owner;
   pol_pkg::id_type  waiters[$];
   pol_pkg::rsp_type owed_rsp[$];
   pol_pkg::rsp_type want;

   assign lock_held  = held;
   assign lock_owner = owner;

   function automatic pol_pkg::rsp_type apply_lock_request(pol_pkg::req_type r);
      pol_pkg::id_type     id;
      pol_pkg::status_type st;
      logic                passed;
      int                  pos;
      pol_pkg::rsp_type    res;
      id = pol_pkg::id_type'(r.requester_id);
      passed = 1'b0;
      if (r.cmd == pol_pkg::CMD_ACQUIRE) begin
         if (!held) begin
            held = 1'b1;
            owner = id;
            st = pol_pkg::ST_GRANTED;
         end else if (waiters.size() >= pol_pkg::QUEUE_DEPTH) begin
            st = pol_pkg::ST_FULL;
         end else begin
            // equal ids stay in arrival order
            pos = waiters.size();
            while (pos > 0 && waiters[pos-1] > id) pos--;
            waiters.insert(pos, id);
            st = pol_pkg::ST_QUEUED;
         end
      end else if (!held || owner != id) begin
         st = pol_pkg::ST_REFUSED;
      end else if (waiters.size() > 0) begin
         owner = waiters.pop_front();
         passed = 1'b1;
         st = pol_pkg::ST_RELEASED;
      end else begin
         held = 1'b0;
         owner = '0;
         st = pol_pkg::ST_RELEASED;
      end
      res.status         = st;
      res.handover_valid = passed;
      res.new_owner_id   = held ? 16'(owner) : 16'd0;
      res.waiting_count  = 7'(waiters.size());
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held = 1'b0;
         owner = '0;
         waiters.delete();
         owed_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_rsp.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected lock response transaction %h", rsp_data);
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.handover_valid !== want.handover_valid ||
                   rsp_data.new_owner_id !== want.new_owner_id ||
                   rsp_data.waiting_count !== want.waiting_count) begin
                  errors++;
                  if (errors <= 10)
                     $display({"lock response mismatch: expected status %0d handover %0b ",
                               "owner %h waiting %0d, got status %0d handover %0b ",
                               "owner %h waiting %0d"},
                              want.status, want.handover_valid, want.new_owner_id,
                              want.waiting_count, rsp_data.status, rsp_data.handover_valid,
                              rsp_data.new_owner_id, rsp_data.waiting_count);
               end
            end
         end
         if (req_valid && req_ready)
            owed_rsp.push_back(apply_lock_request(req_data));
      end
      pending   = owed_rsp.size();
      queue_len = waiters.size();
   end

endmodule

/* test/tb_priority_ordered_lock.sv */
// Testbench top for the priority ordered lock: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_priority_ordered_lock;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   pol_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   pol_pkg::rsp_type rsp_data;

   int               errors;
   int               pending;
   int               queue_len;
   logic             lock_held;
   pol_pkg::id_type  lock_owner;

   logic             idle_on;
   int               stall_left;
   int               issued;
   int               random_start;
   int               settle;
   int               roll;
   logic             first_fill;

   priority_ordered_lock uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   pol_checker lock_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .errors     (errors),
      .pending    (pending),
      .lock_held  (lock_held),
      .lock_owner (lock_owner),
      .queue_len  (queue_len)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // mix of wide random ids, a narrow range for duplicates, and the extremes
   function automatic pol_pkg::id_type pick_id();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 5)
         return pol_pkg::id_type'($urandom_range(0, 65535));
      else if (mode < 8)
         return pol_pkg::id_type'($urandom_range(0, 7));
      else if (mode == 8)
         return '0;
      else
         return '1;
   endfunction

   // entered and left at a falling edge; owner lookup happens after the last update
   task automatic issue(input pol_pkg::cmd_type c, input logic as_owner,
                        input pol_pkg::id_type id);
      int              gap;
      pol_pkg::id_type who;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      who = as_owner ? lock_owner : id;
      req_data  <= '{cmd: c, requester_id: 16'(who)};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      issued++;
      // no idling in the last part of the run
      if (issued - random_start >= 390) idle_on = 1'b0;
      @(negedge clock);
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      idle_on      = 1'b1;
      stall_left   = 0;
      issued       = 0;
      random_start = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'h0005);
      issue(pol_pkg::CMD_ACQUIRE, 1'b0, 16'h0000);
      issue(pol_pkg::CMD_ACQUIRE, 1'b0, 16'hFFFF);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'h0001);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'h0000);
      issue(pol_pkg::CMD_ACQUIRE, 1'b0, 16'hFFFF);
      issue(pol_pkg::CMD_ACQUIRE, 1'b0, 16'h8000);
      issue(pol_pkg::CMD_ACQUIRE, 1'b0, 16'h8000);
      issue(pol_pkg::CMD_ACQUIRE, 1'b0, 16'h0001);
      issue(pol_pkg::CMD_ACQUIRE, 1'b0, 16'h0000);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'hFFFF);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'h0000);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'h0001);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'h8000);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'h8000);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'hFFFF);
      issue(pol_pkg::CMD_ACQUIRE, 1'b0, 16'h5555);
      issue(pol_pkg::CMD_ACQUIRE, 1'b0, 16'hAAAA);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'hAAAA);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'h5555);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'hAAAA);
      issue(pol_pkg::CMD_RELEASE, 1'b0, 16'hAAAA);

      random_start = issued;
      first_fill   = 1'b1;
      while (issued - random_start < 450) begin
         idle_on = (issued - random_start < 390) && ($urandom_range(0, 4) != 0);
         if (first_fill ||
             (issued - random_start < 300 && $urandom_range(0, 11) == 0)) begin
            // fill the queue to the top, push past it, then drain with some noise
            first_fill = 1'b0;
            while (queue_len < pol_pkg::QUEUE_DEPTH)
               issue(pol_pkg::CMD_ACQUIRE, 1'b0, pick_id());
            repeat ($urandom_range(1, 3)) issue(pol_pkg::CMD_ACQUIRE, 1'b0, pick_id());
            while (lock_held) begin
               roll = $urandom_range(0, 9);
               if (roll == 0)
                  issue(pol_pkg::CMD_RELEASE, 1'b0, pick_id());
               else if (roll == 1)
                  issue(pol_pkg::CMD_ACQUIRE, 1'b0, pick_id());
               else
                  issue(pol_pkg::CMD_RELEASE, 1'b1, '0);
            end
         end else begin
            repeat ($urandom_range(1, 12)) begin
               roll = $urandom_range(0, 99);
               if (!lock_held)
                  issue(roll < 85 ? pol_pkg::CMD_ACQUIRE : pol_pkg::CMD_RELEASE, 1'b0,
                        pick_id());
               else if (roll < 40)
                  issue(pol_pkg::CMD_RELEASE, 1'b1, '0);
               else if (roll < 80)
                  issue(pol_pkg::CMD_ACQUIRE, 1'b0, pick_id());
               else if (roll < 90)
                  issue(pol_pkg::CMD_RELEASE, 1'b0, pick_id());
               else
                  issue(pol_pkg::CMD_ACQUIRE, 1'b1, '0);
            end
         end
      end

      req_valid <= 1'b0;
      settle = 0;
      while (pending != 0 && settle < 20000) begin
         @(negedge clock);
         settle++;
      end
      repeat (100) @(negedge clock);
      if (errors == 0 && pending == 0)
         $display("priority_ordered_lock verification clean");
      else
         $display("priority_ordered_lock verification failed");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("priority_ordered_lock verification failed");
      $finish;
   end

endmodule

/* priority_ordered_lock.f */
rtl/pol_pkg.sv
rtl/pol_ctrl.sv
rtl/pol_dpath.sv
rtl/priority_ordered_lock.sv
test/pol_checker.sv
test/tb_priority_ordered_lock.sv
